### rtl/core/mnva_pkg.sv
// Shared types and constants of the MIDI note voice allocator.
package mnva_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned LEVEL_W = 7;
  localparam int unsigned INDEX_W = 3;

  localparam logic [BYTE_W-1:0] STATUS_MASK  = 8'h80;
  localparam logic [BYTE_W-1:0] NIBBLE_MASK  = 8'hF0;
  localparam logic [BYTE_W-1:0] NOTE_ON_CODE = 8'h90;

  // Request handed from the parser to the voice scanner
  typedef struct packed {
    logic               valid;
    logic               is_rel;
    logic [NOTE_W-1:0]  note;
    logic [LEVEL_W-1:0] level;
  } req_t;

  // One result beat
  typedef struct packed {
    logic [INDEX_W-1:0] voice_index;
    logic [NOTE_W-1:0]  voice_note;
    logic [LEVEL_W-1:0] voice_level;
    logic               is_release;
  } res_t;

endpackage

### rtl/core/mnva_in_if.sv
// Input byte channel of the MIDI note voice allocator.
interface mnva_in_if;
  logic                        valid;
  logic                        ready;
  logic [mnva_pkg::BYTE_W-1:0] midi_byte;

  modport source (output valid, output midi_byte, input ready);
  modport sink (input valid, input midi_byte, output ready);
endinterface

### rtl/core/mnva_out_if.sv
// Result channel of the MIDI note voice allocator.
interface mnva_out_if;
  logic                         valid;
  logic                         ready;
  logic [mnva_pkg::INDEX_W-1:0] voice_index;
  logic [mnva_pkg::NOTE_W-1:0]  voice_note;
  logic [mnva_pkg::LEVEL_W-1:0] voice_level;
  logic                         is_release;

  modport source (output valid, output voice_index, output voice_note,
                  output voice_level, output is_release, input ready);
  modport sink (input valid, input voice_index, input voice_note,
                input voice_level, input is_release, output ready);
endinterface

### rtl/core/midi_note_voice_allocator.sv
// Top level of the MIDI note voice allocator.
//
//   channel  dir  beat        fields
//   in_if    in   MIDI byte   midi_byte[7:0]
//   out_if   out  voice event voice_index[2:0] voice_note[6:0] voice_level[6:0] is_release
//
// A status, note or idle data byte only updates the parser. A velocity byte in the
// note-on data phase starts a walk of the voice slots by the single note comparator;
// in_if.ready is low during that walk.
// Reset clears the parser phase and every voice slot at once; no clearing pass.
// The result register lets a new byte be taken while a result waits; a hit found
// while that register is still full holds the walk until out_if takes the beat.
module midi_note_voice_allocator #(
  parameter int unsigned VOICE_COUNT = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mnva_in_if.sink           in_if,
  mnva_out_if.source        out_if
);

  mnva_pkg::req_t req;
  mnva_pkg::res_t res;
  mnva_pkg::res_t out_q;
  logic           res_valid;
  logic           res_ready;
  logic           scan_idle;
  logic           accept;
  logic           out_valid_q;

  assign in_if.ready = scan_idle;
  assign accept      = in_if.valid && scan_idle;

  mnva_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_if.midi_byte),
    .req_o    (req)
  );

  mnva_scan #(
    .VOICE_COUNT (VOICE_COUNT)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .idle_o      (scan_idle)
  );

  // Load the result register when it is empty or being drained
  assign res_ready = !out_valid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.voice_index = out_q.voice_index;
  assign out_if.voice_note  = out_q.voice_note;
  assign out_if.voice_level = out_q.voice_level;
  assign out_if.is_release  = out_q.is_release;

endmodule

### rtl/core/mnva_parse.sv
// Note-on byte parser with running status.
module mnva_parse (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [mnva_pkg::BYTE_W-1:0] byte_i,
  output mnva_pkg::req_t              req_o
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_NOTE = 3'b010,
    PH_VEL  = 3'b100
  } phase_e;

  phase_e                      phase_q, phase_d;
  logic [mnva_pkg::NOTE_W-1:0] pend_q, pend_d;
  logic                        is_status;
  logic                        is_note_on;

  assign is_status  = (byte_i & mnva_pkg::STATUS_MASK) != '0;
  assign is_note_on = (byte_i & mnva_pkg::NIBBLE_MASK) == mnva_pkg::NOTE_ON_CODE;

  // Advance the phase on each accepted beat
  always_comb begin
    phase_d      = phase_q;
    pend_d       = pend_q;
    req_o        = '0;
    req_o.note   = pend_q;
    req_o.level  = byte_i[mnva_pkg::LEVEL_W-1:0];
    req_o.is_rel = byte_i == '0;
    if (accept_i) begin
      if (is_status) begin
        if (phase_q == PH_IDLE && is_note_on) phase_d = PH_NOTE;
      end else begin
        unique case (phase_q)
          PH_NOTE: begin
            pend_d  = byte_i[mnva_pkg::NOTE_W-1:0];
            phase_d = PH_VEL;
          end
          PH_VEL: begin
            phase_d     = PH_NOTE;
            req_o.valid = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pend_q  <= '0;
    end else begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
    end
  end

endmodule

### rtl/core/mnva_scan.sv
// Voice store with a serial scan through one shared note comparator.
module mnva_scan #(
  parameter int unsigned VOICE_COUNT = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mnva_pkg::req_t req_i,
  input  logic           res_ready_i,
  output logic           res_valid_o,
  output mnva_pkg::res_t res_o,
  output logic           idle_o
);

  localparam int unsigned IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICE_COUNT - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e                       state_q, state_d;
  logic [IDX_W-1:0]             idx_q, idx_d;
  logic                         rel_q;
  logic [mnva_pkg::NOTE_W-1:0]  note_q;
  logic [mnva_pkg::LEVEL_W-1:0] level_q;
  logic [mnva_pkg::NOTE_W-1:0]  slot_note_q  [VOICE_COUNT];
  logic [mnva_pkg::NOTE_W-1:0]  target;
  logic                         hit;
  logic                         fire;

  // Shared comparator: free slot on press, matching note on release
  assign target = rel_q ? note_q : '0;
  assign hit    = state_q == ST_SCAN && slot_note_q[idx_q] == target;
  assign fire   = hit && res_ready_i;

  // The new level of a voice is the request level on press and zero on release
  assign idle_o            = state_q == ST_IDLE;
  assign res_valid_o       = hit;
  assign res_o.voice_index = mnva_pkg::INDEX_W'(idx_q);
  assign res_o.voice_note  = rel_q ? '0 : note_q;
  assign res_o.voice_level = rel_q ? '0 : level_q;
  assign res_o.is_release  = rel_q;

  // Sequence the scan; hold on a hit until the result can be taken
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          state_d = ST_SCAN;
          idx_d   = '0;
        end
      end
      ST_SCAN: begin
        if (fire) begin
          state_d = ST_IDLE;
        end else if (!hit) begin
          if (idx_q == LAST_IDX) state_d = ST_IDLE;
          else idx_d = idx_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Latch the request operands
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && req_i.valid) begin
      rel_q   <= req_i.is_rel;
      note_q  <= req_i.note;
      level_q <= req_i.level;
    end
  end

  // Update the voice store when a result goes out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k < VOICE_COUNT; k++) begin
        slot_note_q[k] <= '0;
      end
    end else if (fire) begin
      slot_note_q[idx_q] <= res_o.voice_note;
    end
  end

endmodule

### rtl/core/mnva_chk.sv
// Port-level checks of the MIDI note voice allocator, bound to the top level.
module mnva_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [mnva_pkg::NOTE_W-1:0]  voice_note_i,
  input logic [mnva_pkg::LEVEL_W-1:0] voice_level_i,
  input logic                         is_release_i
);

  // Release beats report a cleared voice
  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_release_i |-> voice_note_i == '0 && voice_level_i == '0)
    else $error("release beat with nonzero note or level");

  // Press beats always carry a nonzero velocity
  a_press_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_release_i |-> voice_level_i != '0)
    else $error("press beat with zero level");

  // A new result never appears right after a byte beat; the scan lies between them
  a_scan_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_valid_i && in_ready_i))
    else $error("result appeared right after a byte beat");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

endmodule

bind midi_note_voice_allocator mnva_chk u_mnva_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .voice_note_i  (out_if.voice_note),
  .voice_level_i (out_if.voice_level),
  .is_release_i  (out_if.is_release)
);

### test/midi_note_voice_allocator_tb.sv
// Self-checking testbench for the MIDI note voice allocator: directed table, then random traffic.
`timescale 1ns / 100ps

module midi_note_voice_allocator_tb;
  import mnva_pkg::*;

  localparam int unsigned VOICE_COUNT = 8;
  localparam int          DATA_ITEMS  = 1700;
  localparam int          HOLD_OFF    = 400;
  localparam int          IDLE_LIMIT  = 4000;
  localparam res_t        NO_EVENT    = '0;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_NOTE = 2'd1,
    PH_VEL  = 2'd2
  } parse_phase_e;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_e;

  // One directed beat; typed rows carry their own expected event
  typedef struct packed {
    logic [BYTE_W-1:0] midi_byte;
    logic              typed;
    logic              has_event;
    res_t              voice_event;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  mnva_in_if  byte_ch ();
  mnva_out_if voice_ch ();

  midi_note_voice_allocator #(
    .VOICE_COUNT(VOICE_COUNT)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (byte_ch),
    .out_if(voice_ch)
  );

  // Allocator shadow state
  parse_phase_e       parse_phase;
  logic [NOTE_W-1:0]  pending_note;
  logic [NOTE_W-1:0]  slot_note  [VOICE_COUNT];
  logic [LEVEL_W-1:0] slot_level [VOICE_COUNT];

  res_t voice_event_q [$];
  int   mismatch_count  = 0;
  int   burst_left      = 0;
  int   bulk_data_beats = 0;
  bit   draining        = 1'b0;

  stim_row_t directed_rows [27] = '{
    // data byte while idle: dropped
    '{8'h45, 1'b1, 1'b0, NO_EVENT},
    // note-on on the highest channel arms the parser
    '{8'h9F, 1'b1, 1'b0, NO_EVENT},
    '{8'h7F, 1'b1, 1'b0, NO_EVENT},
    '{8'h7F, 1'b1, 1'b1, '{3'd0, 7'd127, 7'd127, 1'b0}},
    // another note-on while armed changes nothing
    '{8'h90, 1'b1, 1'b0, NO_EVENT},
    // note zero pressed: stored, slot stays free
    '{8'h00, 1'b1, 1'b0, NO_EVENT},
    '{8'h01, 1'b1, 1'b1, '{3'd1, 7'd0, 7'd1, 1'b0}},
    // note zero released: matches the first free slot
    '{8'h00, 1'b1, 1'b0, NO_EVENT},
    '{8'h00, 1'b1, 1'b1, '{3'd1, 7'd0, 7'd0, 1'b1}},
    // release of a note nobody holds
    '{8'h3C, 1'b1, 1'b0, NO_EVENT},
    '{8'h00, 1'b1, 1'b0, NO_EVENT},
    // fill the remaining slots
    '{8'h01, 1'b0, 1'b0, NO_EVENT},
    '{8'h28, 1'b0, 1'b0, NO_EVENT},
    '{8'h02, 1'b0, 1'b0, NO_EVENT},
    '{8'h01, 1'b0, 1'b0, NO_EVENT},
    '{8'h03, 1'b0, 1'b0, NO_EVENT},
    '{8'h7E, 1'b0, 1'b0, NO_EVENT},
    '{8'h04, 1'b0, 1'b0, NO_EVENT},
    '{8'h22, 1'b0, 1'b0, NO_EVENT},
    '{8'h05, 1'b0, 1'b0, NO_EVENT},
    '{8'h55, 1'b0, 1'b0, NO_EVENT},
    '{8'h06, 1'b0, 1'b0, NO_EVENT},
    '{8'h2A, 1'b0, 1'b0, NO_EVENT},
    '{8'h07, 1'b0, 1'b0, NO_EVENT},
    '{8'h10, 1'b0, 1'b0, NO_EVENT},
    // every slot busy: press is dropped
    '{8'h05, 1'b1, 1'b0, NO_EVENT},
    '{8'h33, 1'b1, 1'b0, NO_EVENT}
  };

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Advance the shadow allocator by one byte; return 1 when a voice changes
  function automatic bit predict_voice_event(input logic [BYTE_W-1:0] b, output res_t ev);
    ev = NO_EVENT;
    if ((b & STATUS_MASK) != '0) begin
      if ((b & NIBBLE_MASK) == NOTE_ON_CODE && parse_phase != PH_NOTE && parse_phase != PH_VEL)
        parse_phase = PH_NOTE;
      return 1'b0;
    end
    if (parse_phase == PH_NOTE) begin
      pending_note = b[NOTE_W-1:0];
      parse_phase  = PH_VEL;
      return 1'b0;
    end
    if (parse_phase != PH_VEL) return 1'b0;
    parse_phase = PH_NOTE;
    for (int k = 0; k < VOICE_COUNT; k++) begin
      if (b == '0 && slot_note[k] == pending_note) begin
        slot_note[k]  = '0;
        slot_level[k] = '0;
        ev = '{INDEX_W'(k), NOTE_W'(0), LEVEL_W'(0), 1'b1};
        return 1'b1;
      end
      if (b != '0 && slot_note[k] == '0) begin
        slot_note[k]  = pending_note;
        slot_level[k] = b[LEVEL_W-1:0];
        ev = '{INDEX_W'(k), pending_note, b[LEVEL_W-1:0], 1'b0};
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Offer one byte in bursts with random gaps; predict on acceptance
  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed, input bit has_event,
                           input res_t typed_event);
    res_t ev;
    bit   hit;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        byte_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk_i);
    byte_ch.valid     <= 1'b1;
    byte_ch.midi_byte <= b;
    do @(posedge clk_i); while (!byte_ch.ready);
    hit = predict_voice_event(b, ev);
    if (typed) begin
      hit = has_event;
      ev  = typed_event;
    end
    if (hit) voice_event_q.push_back(ev);
    burst_left--;
  endtask

  // Stimulus
  initial begin
    logic [NOTE_W-1:0]  note_pool [12];
    logic [NOTE_W-1:0]  note;
    logic [LEVEL_W-1:0] vel;
    int                 pick;

    rst_ni            = 1'b0;
    byte_ch.valid     = 1'b0;
    byte_ch.midi_byte = '0;
    parse_phase       = PH_IDLE;
    pending_note      = '0;
    for (int k = 0; k < VOICE_COUNT; k++) begin
      slot_note[k]  = '0;
      slot_level[k] = '0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].midi_byte, directed_rows[i].typed,
                directed_rows[i].has_event, directed_rows[i].voice_event);

    // Small note pool so that releases find their voices
    foreach (note_pool[i]) note_pool[i] = NOTE_W'($urandom_range(0, 127));

    while (bulk_data_beats < DATA_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // stray status byte: ignored while armed
        send_byte(BYTE_W'($urandom_range(8'h80, 8'hFF)), 1'b0, 1'b0, NO_EVENT);
      end else if (pick < 12) begin
        // lone data byte shifts the note/velocity pairing
        send_byte(BYTE_W'($urandom_range(0, 127)), 1'b0, 1'b0, NO_EVENT);
        bulk_data_beats++;
      end else begin
        note = ($urandom_range(0, 9) < 7) ? note_pool[$urandom_range(0, 11)]
                                          : NOTE_W'($urandom_range(0, 127));
        vel  = ($urandom_range(0, 99) < 45) ? '0 : LEVEL_W'($urandom_range(1, 127));
        send_byte({1'b0, note}, 1'b0, 1'b0, NO_EVENT);
        if ($urandom_range(0, 19) == 0)
          send_byte(BYTE_W'($urandom_range(8'h80, 8'hFF)), 1'b0, 1'b0, NO_EVENT);
        send_byte({1'b0, vel}, 1'b0, 1'b0, NO_EVENT);
        bulk_data_beats += 2;
      end
    end
    @(negedge clk_i);
    byte_ch.valid <= 1'b0;

    // Drain, then give the voice walk time to show any stray beat
    draining = 1'b1;
    while (voice_event_q.size() != 0) @(posedge clk_i);
    repeat (VOICE_COUNT + 16) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: stall patterns and long hold-offs
  initial begin
    rx_mode_e mode;
    int       span;
    int       holdoffs;
    voice_ch.ready = 1'b0;
    holdoffs       = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (holdoffs < 3 && bulk_data_beats >= 400 * (holdoffs + 1) && !draining) begin
        holdoffs++;
        for (int c = 0; c < HOLD_OFF; c++) begin
          @(negedge clk_i);
          voice_ch.ready <= draining;
        end
      end
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      for (int c = 0; c < span; c++) begin
        @(negedge clk_i);
        case (mode)
          RX_OPEN:   voice_ch.ready <= 1'b1;
          RX_COIN:   voice_ch.ready <= draining || ($urandom_range(0, 1) == 1);
          RX_SPARSE: voice_ch.ready <= draining || (c % 4 == 0);
          default:   voice_ch.ready <= draining || ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Compare each result beat with the oldest expected voice event
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && voice_ch.valid && voice_ch.ready) begin
      if (voice_event_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat idx=%0d note=%0d lvl=%0d rel=%0b",
                                  voice_ch.voice_index, voice_ch.voice_note,
                                  voice_ch.voice_level, voice_ch.is_release));
      end else begin
        want = voice_event_q.pop_front();
        if (voice_ch.voice_index !== want.voice_index)
          report_mismatch($sformatf("voice_index got %0d want %0d",
                                    voice_ch.voice_index, want.voice_index));
        if (voice_ch.voice_note !== want.voice_note)
          report_mismatch($sformatf("voice_note got %0d want %0d",
                                    voice_ch.voice_note, want.voice_note));
        if (voice_ch.voice_level !== want.voice_level)
          report_mismatch($sformatf("voice_level got %0d want %0d",
                                    voice_ch.voice_level, want.voice_level));
        if (voice_ch.is_release !== want.is_release)
          report_mismatch($sformatf("is_release got %0b want %0b",
                                    voice_ch.is_release, want.is_release));
      end
    end
  end

  // Watchdog: end the run after too many cycles without a beat on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (byte_ch.valid && byte_ch.ready) || (voice_ch.valid && voice_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("ERROR at %0t: no beat for %0d cycles", $realtime, IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

endmodule

### filelist.f
rtl/core/mnva_pkg.sv
rtl/core/mnva_in_if.sv
rtl/core/mnva_out_if.sv
rtl/core/mnva_parse.sv
rtl/core/mnva_scan.sv
rtl/core/midi_note_voice_allocator.sv
rtl/core/mnva_chk.sv
test/midi_note_voice_allocator_tb.sv
